/* hw/rtl/mlt_pkg.sv */
// Shared types, constants and helper functions of the MAC learning table.
package mlt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int MIN_TABLE_DEPTH     = 16;

   localparam int PORT_W = 8;
   localparam int AGE_W  = 8;
   localparam int MAC_W  = 48;
   localparam int KEY_W  = 16;          // byte5:byte4 of the MAC
   localparam int SLOT_W = KEY_W;       // widest slot index the table can need
   localparam int DEPTH_W = KEY_W + 1;  // holds the table depth itself

   // reciprocal for the slot reduction: floor(2^32 / depth), depth >= MIN_TABLE_DEPTH
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W = RECIP_SHIFT - $clog2(MIN_TABLE_DEPTH) + 1;

   localparam int QUEUE_DEPTH = 2;

   // opcodes
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_RELOAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_STEP   = 2'd1;

   localparam logic [AGE_W-1:0] AGE_RELOAD_RESET = 8'd60;
   localparam logic [AGE_W-1:0] AGE_STEP_RESET   = 8'd10;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [AGE_W-1:0]  age;
      logic [MAC_W-1:0]  mac;
   } mlt_entry_type;

   typedef struct packed {
      logic              opcode;
      logic [PORT_W-1:0] in_port;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [SLOT_W-1:0] src_slot;
      logic [SLOT_W-1:0] dst_slot;
   } mlt_cmd_type;

   typedef struct packed {
      logic [AGE_W-1:0] age_reload;
      logic [AGE_W-1:0] age_step;
   } mlt_cfg_type;

   function automatic logic [KEY_W-1:0] mlt_key(input logic [MAC_W-1:0] mac);
      return {mac[7:0], mac[15:8]};
   endfunction

   // one aging step of an entry; an entry whose age ends at zero is wiped
   function automatic mlt_entry_type mlt_age_entry(input mlt_entry_type e,
                                                   input logic [AGE_W-1:0] step);
      mlt_entry_type r;
      r = e;
      if (e.port != '0) begin
         r.age = (e.age > step) ? (e.age - step) : '0;
      end
      if (r.age == '0) begin
         r = '0;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/mlt_front.sv */
// Front end: accepts beats and reduces both MAC keys to table slots.
module mlt_front import mlt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [PORT_W-1:0] req_in_port,
   input  logic [MAC_W-1:0]  req_src_mac,
   input  logic [MAC_W-1:0]  req_dst_mac,
   output logic              push_valid,
   input  logic              push_ready,
   output mlt_cmd_type       push_data
);

   localparam int PROD_W = KEY_W + RECIP_W;
   localparam int Q_W    = PROD_W - RECIP_SHIFT;
   localparam int QD_W   = Q_W + DEPTH_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / TABLE_DEPTH);
   localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(TABLE_DEPTH);

   logic advance;

   // stage 1: key times reciprocal
   logic              s1_valid_ff;
   mlt_cmd_type       s1_cmd_ff;
   logic [KEY_W-1:0]  s1_src_key_ff, s1_dst_key_ff;
   logic [PROD_W-1:0] s1_src_prod_ff, s1_dst_prod_ff;

   // stage 2: estimated quotient times depth
   logic              s2_valid_ff;
   mlt_cmd_type       s2_cmd_ff;
   logic [KEY_W-1:0]  s2_src_key_ff, s2_dst_key_ff;
   logic [QD_W-1:0]   s2_src_qd_ff, s2_dst_qd_ff;

   logic [KEY_W-1:0]   src_key_in, dst_key_in;
   mlt_cmd_type        cmd_in;
   logic [DEPTH_W-1:0] src_diff, dst_diff, src_rem, dst_rem;

   assign advance   = !s2_valid_ff || push_ready;
   assign req_ready = advance;

   assign src_key_in = mlt_key(req_src_mac);
   assign dst_key_in = mlt_key(req_dst_mac);

   always_comb begin
      cmd_in          = '0;
      cmd_in.opcode   = req_opcode;
      cmd_in.in_port  = req_in_port;
      cmd_in.src_mac  = req_src_mac;
      cmd_in.dst_mac  = req_dst_mac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff      <= cmd_in;
         s1_src_key_ff  <= src_key_in;
         s1_dst_key_ff  <= dst_key_in;
         s1_src_prod_ff <= PROD_W'(src_key_in) * PROD_W'(RECIP);
         s1_dst_prod_ff <= PROD_W'(dst_key_in) * PROD_W'(RECIP);
         s2_cmd_ff      <= s1_cmd_ff;
         s2_src_key_ff  <= s1_src_key_ff;
         s2_dst_key_ff  <= s1_dst_key_ff;
         s2_src_qd_ff   <= QD_W'(s1_src_prod_ff[PROD_W-1:RECIP_SHIFT]) * QD_W'(DEPTH_C);
         s2_dst_qd_ff   <= QD_W'(s1_dst_prod_ff[PROD_W-1:RECIP_SHIFT]) * QD_W'(DEPTH_C);
      end
   end

   // quotient estimate is exact or one low: one correction step
   always_comb begin
      src_diff = {1'b0, s2_src_key_ff} - s2_src_qd_ff[DEPTH_W-1:0];
      dst_diff = {1'b0, s2_dst_key_ff} - s2_dst_qd_ff[DEPTH_W-1:0];
      src_rem  = (src_diff >= DEPTH_C) ? (src_diff - DEPTH_C) : src_diff;
      dst_rem  = (dst_diff >= DEPTH_C) ? (dst_diff - DEPTH_C) : dst_diff;
      push_data          = s2_cmd_ff;
      push_data.src_slot = src_rem[SLOT_W-1:0];
      push_data.dst_slot = dst_rem[SLOT_W-1:0];
   end

   assign push_valid = s2_valid_ff;

endmodule

/* hw/rtl/mlt_queue.sv */
// Short command queue between the front end and the table engine.
module mlt_queue import mlt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  mlt_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output mlt_cmd_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   mlt_cmd_type      slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/mlt_back.sv */
// Table engine: entry memory, clearing pass, learn/lookup and aging walk.
module mlt_back import mlt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  mlt_cfg_type       cfg,
   input  logic              q_valid,
   output logic              q_pop,
   input  mlt_cmd_type       q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PORT_W-1:0] rsp_out_port,
   output logic              rsp_hit
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LEARN  = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_AGE    = 3'd4;

   mlt_entry_type mem [TABLE_DEPTH];
   mlt_entry_type rd_data_ff;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   mlt_cmd_type       cmd_ff, cmd_in;
   logic              fwd_ff, fwd_in;
   mlt_entry_type     fwd_entry_ff, fwd_entry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic              rsp_hit_ff, rsp_hit_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   mlt_entry_type     mem_wd;
   logic              out_free;
   mlt_entry_type     learned, looked;
   logic [IDX_W-1:0]  src_idx, dst_idx, head_src_idx, head_dst_idx;
   logic              match;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign src_idx      = cmd_ff.src_slot[IDX_W-1:0];
   assign dst_idx      = cmd_ff.dst_slot[IDX_W-1:0];
   assign head_src_idx = q_data.src_slot[IDX_W-1:0];
   assign head_dst_idx = q_data.dst_slot[IDX_W-1:0];

   always_comb begin
      // learn: port always becomes in_port; MAC only replaced on a port change
      learned      = rd_data_ff;
      learned.port = cmd_ff.in_port;
      learned.age  = cfg.age_reload;
      if (rd_data_ff.port != cmd_ff.in_port) begin
         learned.mac = cmd_ff.src_mac;
      end
      looked = fwd_ff ? fwd_entry_ff : rd_data_ff;
      match  = (looked.port != '0) && (looked.mac == cmd_ff.dst_mac);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      fwd_in       = fwd_ff;
      fwd_entry_in = fwd_entry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_port_in  = rsp_port_ff;
      rsp_hit_in   = rsp_hit_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = '0;
      mem_ra       = '0;
      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               if (q_data.opcode == OP_TICK) begin
                  idx_in   = '0;
                  mem_ra   = '0;
                  state_in = ST_AGE;
               end else if (q_data.in_port != '0) begin
                  mem_ra   = head_src_idx;
                  state_in = ST_LEARN;
               end else begin
                  mem_ra   = head_dst_idx;
                  fwd_in   = 1'b0;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LEARN: begin
            mem_we       = 1'b1;
            mem_wa       = src_idx;
            mem_wd       = learned;
            mem_ra       = dst_idx;
            fwd_in       = (dst_idx == src_idx);
            fwd_entry_in = learned;
            state_in     = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = match;
            rsp_port_in  = match ? looked.port : '0;
            state_in     = ST_IDLE;
         end
         ST_AGE: begin
            // write back entry idx while the next one is being read
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = mlt_age_entry(rd_data_ff, cfg.age_step);
            mem_ra = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               idx_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_port_in  = '0;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_INIT;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      fwd_ff       <= fwd_in;
      fwd_entry_ff <= fwd_entry_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_port = rsp_port_ff;
   assign rsp_hit      = rsp_hit_ff;

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> out_free)
      else $error("command taken while the result register is still occupied");

   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !q_pop)
      else $error("command taken during the clearing pass");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |->
         ($past(state_ff) == ST_LOOKUP || $past(state_ff) == ST_AGE))
      else $error("result raised outside lookup or end of aging walk");

   a_hit_has_port: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_port_ff != '0))
      else $error("hit reported with an empty port");

endmodule

/* hw/rtl/mac_learning_table_with_aging.sv */
// Top level of the direct-mapped MAC learning table with aging.
//
// Direct-mapped layer-2 table of TABLE_DEPTH entries (port, age, MAC). A frame beat
// (opcode 0) learns its source MAC into slot ({byte5,byte4} mod TABLE_DEPTH),
// reloading the age, unless in_port is 0, and then looks up its destination MAC and
// returns the stored port on a full 48-bit match, else 0. A tick beat (opcode 1)
// walks the whole table, lowering ages by age_step and wiping entries that reach
// zero; it answers with port 0, hit 0. Every request beat yields exactly one
// response beat, in order. The front end reduces both keys in a 2-stage pipeline
// (reciprocal multiply, then quotient times depth, corrected after) and feeds a
// 2-deep command queue, so requests are taken while the engine is busy or a response
// waits, until queue and pipeline fill. The entry memory has one read and one write
// port: a learning frame reads, writes and compares; a frame with in_port 0 reads
// and compares; a tick ages one entry per cycle. A clearing pass after reset zeroes
// the memory; no request is served before it ends. CSR writes are always taken
// (ready tied high); they must only be issued while the block is idle. Indexes other
// than age_reload (0) and age_step (1) are ignored.
module mac_learning_table_with_aging import mlt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  logic [PORT_W-1:0]    req_in_port,
   input  logic [MAC_W-1:0]     req_src_mac,
   input  logic [MAC_W-1:0]     req_dst_mac,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PORT_W-1:0]    rsp_out_port,
   output logic                 rsp_hit,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [AGE_W-1:0]     csr_data
);

   mlt_cfg_type cfg_ff;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   mlt_cmd_type push_data, pop_data;

   // config registers: never back-pressured
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.age_reload <= AGE_RELOAD_RESET;
         cfg_ff.age_step   <= AGE_STEP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AGE_RELOAD: cfg_ff.age_reload <= csr_data;
            CSR_AGE_STEP:   cfg_ff.age_step   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // key reduction
   mlt_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_in_port (req_in_port),
      .req_src_mac (req_src_mac),
      .req_dst_mac (req_dst_mac),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // decouples front end from the engine
   mlt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // table engine and response register
   mlt_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (pop_valid),
      .q_pop        (pop_ready),
      .q_data       (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_port (rsp_out_port),
      .rsp_hit      (rsp_hit)
   );

endmodule

/* bench/testbench.sv */
// Self-checking bench for the MAC learning table: mirror table, scoreboard and beat drivers.

typedef struct packed {
   logic [mlt_pkg::PORT_W-1:0] port;
   logic                       hit;
} lookup_reply_type;

// Mirror of the switch table; predicts the reply of every accepted request beat
class mac_table_tracker;
   mlt_pkg::mlt_entry_type mirror [mlt_pkg::DEFAULT_TABLE_DEPTH];
   logic [mlt_pkg::AGE_W-1:0] age_reload;
   logic [mlt_pkg::AGE_W-1:0] age_step;
   lookup_reply_type predicted_replies [$];
   int unsigned errors;

   function new();
      foreach (mirror[i]) mirror[i] = '0;
      age_reload = mlt_pkg::AGE_RELOAD_RESET;
      age_step   = mlt_pkg::AGE_STEP_RESET;
      errors     = 0;
   endfunction

   function void write_register(logic [mlt_pkg::CSR_IDX_W-1:0] index,
                                logic [mlt_pkg::AGE_W-1:0] data);
      case (index)
         mlt_pkg::CSR_AGE_RELOAD: age_reload = data;
         mlt_pkg::CSR_AGE_STEP:   age_step   = data;
         default: ;
      endcase
   endfunction

   function int unsigned slot_of(logic [mlt_pkg::MAC_W-1:0] mac);
      logic [15:0] key;
      key = {mac[7:0], mac[15:8]};
      return int'(key) % mlt_pkg::DEFAULT_TABLE_DEPTH;
   endfunction

   function void note_request(logic opcode, logic [mlt_pkg::PORT_W-1:0] in_port,
                              logic [mlt_pkg::MAC_W-1:0] src_mac,
                              logic [mlt_pkg::MAC_W-1:0] dst_mac);
      lookup_reply_type reply;
      int unsigned s;
      reply = '0;
      if (opcode == mlt_pkg::OP_TICK) begin
         foreach (mirror[i]) begin
            if (mirror[i].port != '0) begin
               mirror[i].age = (mirror[i].age > age_step) ? mirror[i].age - age_step : '0;
            end
            if (mirror[i].age == '0) mirror[i] = '0;
         end
      end else begin
         if (in_port != '0) begin
            s = slot_of(src_mac);
            // same port keeps the stored address, only the age is refreshed
            if (mirror[s].port != in_port) begin
               mirror[s].port = in_port;
               mirror[s].mac  = src_mac;
            end
            mirror[s].age = age_reload;
         end
         s = slot_of(dst_mac);
         if (mirror[s].port != '0 && mirror[s].mac == dst_mac) begin
            reply.port = mirror[s].port;
            reply.hit  = 1'b1;
         end
      end
      predicted_replies.push_back(reply);
   endfunction

   function void check_reply(logic [mlt_pkg::PORT_W-1:0] out_port, logic hit,
                             longint unsigned stamp);
      lookup_reply_type want;
      if (predicted_replies.size() == 0) begin
         $display("%0d ns: reply beat with nothing outstanding: port %0d hit %0d",
                  stamp, out_port, hit);
         errors++;
         return;
      end
      want = predicted_replies.pop_front();
      if (out_port !== want.port) begin
         $display("%0d ns: out_port expected %0d, got %0d", stamp, want.port, out_port);
         errors++;
      end
      if (hit !== want.hit) begin
         $display("%0d ns: hit expected %0d, got %0d", stamp, want.hit, hit);
         errors++;
      end
   endfunction

   function int unsigned outstanding();
      return predicted_replies.size();
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mlt_pkg::*;

   // register indexes the block does not decode; writes to them must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int unsigned CYCLE_LIMIT = 5_000_000;
   localparam int unsigned PHASE_BEATS = 85;
   localparam int          POOL_SIZE   = 32;
   localparam int unsigned SETTLE_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic                 req_opcode  = OP_FRAME;
   logic [PORT_W-1:0]    req_in_port = '0;
   logic [MAC_W-1:0]     req_src_mac = '0;
   logic [MAC_W-1:0]     req_dst_mac = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PORT_W-1:0]    rsp_out_port;
   logic                 rsp_hit;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_AGE_RELOAD;
   logic [AGE_W-1:0]     csr_data  = '0;

   // per-cent chance per cycle that the sender holds off / the receiver stalls
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count = 0;

   logic [MAC_W-1:0] mac_pool [POOL_SIZE];

   mac_table_tracker tracker = new();

   mac_learning_table_with_aging #(
      .TABLE_DEPTH (DEFAULT_TABLE_DEPTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_in_port  (req_in_port),
      .req_src_mac  (req_src_mac),
      .req_dst_mac  (req_dst_mac),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_port (rsp_out_port),
      .rsp_hit      (rsp_hit),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A tick walks the whole table, so the limit covers every beat being a
   // tick under worst-case stalls, several times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Reply side: check every beat taken, then pick ready for the next edge.
   // Ready may drop freely; the block must hold the beat until taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            tracker.check_reply(rsp_out_port, rsp_hit, longint'($time));
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [MAC_W-1:0] random_mac();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[MAC_W-1:0];
   endfunction

   // Present one request beat and hold it until taken. Valid stays high from
   // one beat into the next unless the sender chooses to idle first, so valid
   // never sees two updates in one step.
   task automatic send_request(input logic opcode, input logic [PORT_W-1:0] in_port,
                               input logic [MAC_W-1:0] src_mac,
                               input logic [MAC_W-1:0] dst_mac);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= opcode;
      req_in_port <= in_port;
      req_src_mac <= src_mac;
      req_dst_mac <= dst_mac;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(opcode, in_port, src_mac, dst_mac);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [AGE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(index, data);
   endtask

   // only ever called with the block idle; spare writes go before and between
   // the real ones, so only a spare write that corrupts age_reload would show
   task automatic configure(input logic [AGE_W-1:0] reload, input logic [AGE_W-1:0] step,
                            input bit with_spares);
      if (with_spares) write_register(CSR_SPARE_A, AGE_W'($urandom));
      write_register(CSR_AGE_RELOAD, reload);
      if (with_spares) write_register(CSR_SPARE_B, AGE_W'($urandom));
      write_register(CSR_AGE_STEP, step);
      csr_valid <= 1'b0;
   endtask

   // Caller has already lowered req_valid. Waits until every predicted reply
   // has been taken; the timeout covers a block that never answers.
   task automatic wait_for_drain();
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // One setting of the registers and of the idling pattern. Frames mostly
   // draw addresses from a small pool so that learns, refreshes, port moves,
   // slot collisions and lookup hits keep recurring; the rest is noise.
   task automatic run_phase(input logic [AGE_W-1:0] reload, input logic [AGE_W-1:0] step,
                            input int unsigned idle_pct, input int unsigned stall_pct,
                            input bit with_spares);
      logic              opcode;
      logic [PORT_W-1:0] in_port;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      int unsigned       pick;
      configure(reload, step, with_spares);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
         opcode  = ($urandom_range(15) == 0) ? OP_TICK : OP_FRAME;
         pick    = $urandom_range(19);
         in_port = (pick == 0) ? '0 :
                   (pick < 12) ? PORT_W'($urandom_range(1, 4)) : PORT_W'($urandom);
         src_mac = ($urandom_range(3) == 0) ? random_mac() :
                   mac_pool[$urandom_range(POOL_SIZE - 1)];
         pick    = $urandom_range(5);
         dst_mac = (pick == 0) ? random_mac() :
                   (pick == 1) ? src_mac : mac_pool[$urandom_range(POOL_SIZE - 1)];
         send_request(opcode, in_port, src_mac, dst_mac);
         // halfway through, hold the sender back until the block is empty
         if (n == PHASE_BEATS / 2) begin
            req_valid <= 1'b0;
            wait_for_drain();
         end
      end
      req_valid <= 1'b0;
      wait_for_drain();
      // the engine is idle once the last reply is taken; the pause is only margin
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [MAC_W-1:0] ones;
      logic [MAC_W-1:0] addr_a;
      logic [MAC_W-1:0] addr_a_twin;
      logic [MAC_W-1:0] addr_b;

      ones        = '1;
      addr_a      = 48'h02_00_00_00_12_34;
      addr_a_twin = 48'h0A_BC_DE_F0_12_34;   // same slot as addr_a
      addr_b      = 48'h00_11_22_33_44_55;

      // the odd entries from 9 on collide with the entry 8 before them; the rest are fresh
      for (int i = 0; i < POOL_SIZE; i++) begin
         mac_pool[i] = random_mac();
         if (i >= 8 && (i % 2) == 1) begin
            mac_pool[i][15:8] = mac_pool[i-8][15:8];
            mac_pool[i][1:0]  = mac_pool[i-8][1:0];
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset values of the registers (60 / 10).
      // The clearing pass after reset is covered by waiting on req_ready.
      send_request(OP_FRAME, 8'd1,   ones, ones);           // all-ones learn + hit
      send_request(OP_FRAME, 8'd255, '0,   '0);             // zero address is valid
      send_request(OP_FRAME, 8'd0,   addr_b, addr_b);       // port zero: no learn
      send_request(OP_FRAME, 8'd0,   random_mac(), ones);   // port zero still looks up
      send_request(OP_FRAME, 8'd7,   addr_a, addr_b);       // unknown destination
      send_request(OP_FRAME, 8'd7,   addr_a_twin, addr_a);  // same port keeps old address
      send_request(OP_FRAME, 8'd7,   addr_b, addr_a_twin);
      send_request(OP_FRAME, 8'd9,   addr_a_twin, addr_a);  // port move overwrites
      send_request(OP_FRAME, 8'd9,   addr_b, addr_a_twin);
      send_request(OP_TICK,  8'd0,   ones, ones);           // tick answers 0 / 0
      send_request(OP_FRAME, 8'd3,   ones, addr_b);         // relearn with new port
      repeat (5) send_request(OP_TICK, PORT_W'($urandom), random_mac(), random_mac());
      send_request(OP_FRAME, 8'd0,   '0, ones);             // still alive, age 10
      send_request(OP_FRAME, 8'd0,   '0, addr_a_twin);      // aged out
      send_request(OP_TICK,  8'hFF,  ones, '0);             // step equals age: cleared
      send_request(OP_FRAME, 8'd0,   ones, ones);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      run_phase(8'd60,  8'd10,  0,  0,  1'b0);   // reset values written back, no idling
      run_phase(8'd255, 8'd1,   58, 0,  1'b1);   // long life, spare indexes written
      run_phase(8'd1,   8'd255, 0,  58, 1'b0);   // step beyond age: saturates to zero
      run_phase(8'd0,   8'd0,   35, 35, 1'b0);   // zero reload: gone at next tick
      run_phase(8'd200, 8'd0,   0,  0,  1'b0);   // zero step: ages never fall
      run_phase(AGE_W'($urandom_range(1, 255)), AGE_W'($urandom_range(1, 255)),
                35, 35, 1'b1);
      run_phase(8'd255, 8'd255, 58, 0,  1'b0);

      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* mac_learning_table_with_aging.f */
hw/rtl/mlt_pkg.sv
hw/rtl/mlt_front.sv
hw/rtl/mlt_queue.sv
hw/rtl/mlt_back.sv
hw/rtl/mac_learning_table_with_aging.sv
bench/testbench.sv
